@@ sv/cv2d_pkg.sv @@
// Shared types and constants for the 2-D convolution window block.
package cv2d_pkg;

   localparam int PIX_W      = 16;
   localparam int COEF_W     = 18;
   localparam int PROD_W     = PIX_W + COEF_W;
   localparam int CIDX_W     = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int FIFO_DEPTH = 8;
   localparam int FRAC_SHIFT = 15;
   localparam int ROUND_BIAS = 16384;
   localparam int PIX_MAX    = 32767;
   localparam int PIX_MIN    = -32768;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROWS  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COLS  = CSR_IDX_W'(3);

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_COEF  = 1'b1;

   typedef logic signed [PIX_W-1:0]  pix_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      logic [7:0] out_row;
      logic [7:0] out_col;
      pix_type    out_value;
      logic       frame_last;
   } rsp_word_type;

endpackage

@@ sv/cv2d_ifs.sv @@
// Channel interfaces: request stream, result stream and register write port.
interface cv2d_req_if import cv2d_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [PIX_W-1:0] pixel_value;
   logic [CIDX_W-1:0]       coef_index;
   logic signed [COEF_W-1:0] coef_value;
   modport source (output valid, req_type, pixel_value, coef_index, coef_value, input ready);
   modport sink (input valid, req_type, pixel_value, coef_index, coef_value, output ready);
endinterface

interface cv2d_rsp_if import cv2d_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [7:0]              out_row;
   logic [7:0]              out_col;
   logic signed [PIX_W-1:0] out_value;
   logic                    frame_last;
   modport source (output valid, out_row, out_col, out_value, frame_last, input ready);
   modport sink (input valid, out_row, out_col, out_value, frame_last, output ready);
endinterface

interface cv2d_csr_if import cv2d_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/cv2d_line_buf.sv @@
// Line stores: one memory per buffered row, written at the column, all read at the column.
module cv2d_line_buf import cv2d_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_KERNEL = 5,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int SW = $clog2(MAX_KERNEL)
) (
   input  logic          clock,
   input  logic          access,
   input  logic [SW-1:0] wr_slot,
   input  logic [CW-1:0] addr,
   input  pix_type       wr_data,
   output pix_type       rd_data [MAX_KERNEL]
);

   for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_line
      pix_type mem [MAX_WIDTH];
      pix_type rd_ff;

      always_ff @(posedge clock) begin
         if (access) begin
            if (wr_slot == SW'(k)) begin
               mem[addr] <= wr_data;
            end
            rd_ff <= mem[addr];
         end
      end

      assign rd_data[k] = rd_ff;
   end

endmodule

@@ sv/cv2d_cell.sv @@
// Window column cell: holds one column, shifts it left, multiplies by its taps, sums.
module cv2d_cell import cv2d_pkg::*; #(
   parameter int MAX_KERNEL = 5,
   localparam int CSUM_W = PROD_W + $clog2(MAX_KERNEL)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  pix_type                  col_in   [MAX_KERNEL],
   input  coef_type                 coef_col [MAX_KERNEL],
   output pix_type                  col_out  [MAX_KERNEL],
   output logic signed [CSUM_W-1:0] col_sum
);

   pix_type                  pix_ff  [MAX_KERNEL];
   logic signed [PROD_W-1:0] prod_ff [MAX_KERNEL];
   logic signed [CSUM_W-1:0] sum_in;
   logic signed [CSUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KERNEL; i++) begin
            pix_ff[i] <= '0;
         end
      end else if (shift_en) begin
         pix_ff <= col_in;
      end
   end

   // a zero tap gives zero whatever the pixel holds
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         if (coef_col[i] == '0) begin
            prod_ff[i] <= '0;
         end else begin
            prod_ff[i] <= pix_ff[i] * coef_col[i];
         end
      end
      sum_ff <= sum_in;
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         sum_in = sum_in + CSUM_W'(prod_ff[i]);
      end
   end

   assign col_out = pix_ff;
   assign col_sum = sum_ff;

endmodule

@@ sv/cv2d_out_fifo.sv @@
// Result queue between the arithmetic pipeline and the result channel.
module cv2d_out_fifo import cv2d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   input  logic         pop,
   output logic         head_valid,
   output rsp_word_type head_word
);

   localparam int PW = $clog2(FIFO_DEPTH);

   rsp_word_type        mem [FIFO_DEPTH];
   logic [PW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]         cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_word;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head_word  = mem[rd_ff];

endmodule

@@ sv/conv2d_valid_window.sv @@
// Top level: position counters, line stores, chain of window cells, adder and result queue.
// Result path: input register, window cell, product, column sum and total, then the queue.
// Throughput: one word (pixel or coefficient) per cycle; set by the single-port line stores.
// Input stalls only when 8 results are queued or in flight behind a stalled result channel.
// Reset: counters, window, coefficients and registers cleared to defaults; no memory sweep.
module conv2d_valid_window import cv2d_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_KERNEL = 5
) (
   input logic        clock,
   input logic        reset,
   cv2d_req_if.sink   req_bus,
   cv2d_rsp_if.source rsp_bus,
   cv2d_csr_if.sink   csr_bus
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
   localparam int SW     = $clog2(MAX_KERNEL);
   localparam int KI     = $clog2(MAX_KERNEL);
   localparam int TI_W   = ($clog2(MAX_KERNEL * MAX_KERNEL) > CIDX_W) ?
                           $clog2(MAX_KERNEL * MAX_KERNEL) : CIDX_W;
   localparam int CSUM_W = PROD_W + $clog2(MAX_KERNEL);
   localparam int TOT_W  = CSUM_W + $clog2(MAX_KERNEL);
   localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);
   localparam int NST    = 5;

   // registers
   logic [8:0] img_w_ff, img_h_ff;
   logic [2:0] k_rows_ff, k_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= 9'd256;
         img_h_ff  <= 9'd256;
         k_rows_ff <= 3'd3;
         k_cols_ff <= 3'd3;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_IMAGE_WIDTH:  img_w_ff  <= csr_bus.data;
            CSR_IMAGE_HEIGHT: img_h_ff  <= csr_bus.data;
            CSR_KERNEL_ROWS:  k_rows_ff <= csr_bus.data[2:0];
            CSR_KERNEL_COLS:  k_cols_ff <= csr_bus.data[2:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // effective sizes
   logic [WW-1:0] width_eff;
   logic [8:0]    height_eff;
   logic [3:0]    kr_clamp, kc_clamp;
   logic [1:0]    hr, hc;
   logic [KI-1:0] offr, offc;

   always_comb begin
      if (img_w_ff == '0) width_eff = WW'(1);
      else if (WW'(img_w_ff) > WW'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
      else width_eff = WW'(img_w_ff);
      height_eff = (img_h_ff == '0) ? 9'd1 : ((img_h_ff > 9'd256) ? 9'd256 : img_h_ff);
      if (k_rows_ff == '0) kr_clamp = 4'd1;
      else if ({1'b0, k_rows_ff} > 4'(MAX_KERNEL)) kr_clamp = 4'(MAX_KERNEL);
      else kr_clamp = {1'b0, k_rows_ff};
      if (k_cols_ff == '0) kc_clamp = 4'd1;
      else if ({1'b0, k_cols_ff} > 4'(MAX_KERNEL)) kc_clamp = 4'(MAX_KERNEL);
      else kc_clamp = {1'b0, k_cols_ff};
      hr   = 2'((kr_clamp - 4'd1) >> 1);
      hc   = 2'((kc_clamp - 4'd1) >> 1);
      offr = KI'(MAX_KERNEL - 1) - KI'({hr, 1'b0});
      offc = KI'(MAX_KERNEL - 1) - KI'({hc, 1'b0});
   end

   // request side
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             req_acc, pix_acc, coef_acc, res_acc, rsp_pop;

   assign req_bus.ready = (occ_ff < OCC_W'(FIFO_DEPTH));
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign pix_acc  = req_acc && (req_bus.req_type == REQ_PIXEL);
   assign coef_acc = req_acc && (req_bus.req_type == REQ_COEF);

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [7:0]    row_ff, row_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [WW-1:0] c0, cn;
   logic [8:0]    r0, rn;
   logic [SW-1:0] s0, sn;
   logic          pos_valid, pos_last;
   logic [7:0]    pos_row, pos_col;

   always_comb begin
      c0 = WW'(col_ff);
      r0 = {1'b0, row_ff};
      s0 = slot_ff;
      if (c0 >= width_eff) begin
         c0 = '0;
         r0 = r0 + 9'd1;
         s0 = (s0 == SW'(MAX_KERNEL - 1)) ? '0 : s0 + 1'b1;
      end
      if (r0 >= height_eff) begin
         r0 = '0;
         s0 = '0;
      end
      cn = c0 + 1'b1;
      rn = r0;
      sn = s0;
      if (cn >= width_eff) begin
         cn = '0;
         rn = r0 + 9'd1;
         sn = (s0 == SW'(MAX_KERNEL - 1)) ? '0 : s0 + 1'b1;
         if (rn >= height_eff) begin
            rn = '0;
            sn = '0;
         end
      end
      col_in    = CW'(cn);
      row_in    = rn[7:0];
      slot_in   = sn;
      pos_valid = (r0 >= 9'({hr, 1'b0})) && (c0 >= WW'({hc, 1'b0}));
      pos_last  = (r0 == height_eff - 9'd1) && (c0 == width_eff - WW'(1));
      pos_row   = 8'(r0 - 9'(hr));
      pos_col   = 8'(c0 - WW'(hc));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (pix_acc) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // line stores
   pix_type rd_data [MAX_KERNEL];

   cv2d_line_buf #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_lines (
      .clock   (clock),
      .access  (pix_acc),
      .wr_slot (s0),
      .addr    (CW'(c0)),
      .wr_data (req_bus.pixel_value),
      .rd_data (rd_data)
   );

   // first stage
   logic          px_v_ff;
   pix_type       px_ff;
   logic [SW-1:0] px_slot_ff;
   logic          cw1_v_ff, cw2_v_ff;
   logic [CIDX_W-1:0] cw1_idx_ff, cw2_idx_ff;
   coef_type      cw1_val_ff, cw2_val_ff;
   logic          mv_ff [1:NST];
   rsp_word_type  m_ff  [1:NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         px_v_ff  <= 1'b0;
         cw1_v_ff <= 1'b0;
         cw2_v_ff <= 1'b0;
         for (int k = 1; k <= NST; k++) begin
            mv_ff[k] <= 1'b0;
         end
      end else begin
         px_v_ff  <= pix_acc;
         cw1_v_ff <= coef_acc;
         cw2_v_ff <= cw1_v_ff;
         mv_ff[1] <= pix_acc && pos_valid;
         for (int k = 2; k <= NST; k++) begin
            mv_ff[k] <= mv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff      <= req_bus.pixel_value;
      px_slot_ff <= s0;
      cw1_idx_ff <= req_bus.coef_index;
      cw1_val_ff <= req_bus.coef_value;
      cw2_idx_ff <= cw1_idx_ff;
      cw2_val_ff <= cw1_val_ff;
      m_ff[1]    <= '{out_row: pos_row, out_col: pos_col, out_value: '0,
                      frame_last: pos_last};
      for (int k = 2; k <= NST; k++) begin
         m_ff[k] <= m_ff[k-1];
      end
   end

   // new window column: oldest line at the top, current pixel at the bottom
   pix_type        new_col [MAX_KERNEL];
   logic [SW:0]    slot_sum [MAX_KERNEL];

   always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         slot_sum[i] = (SW+1)'(px_slot_ff) + (SW+1)'(i + 1);
         if (slot_sum[i] >= (SW+1)'(MAX_KERNEL)) begin
            slot_sum[i] = slot_sum[i] - (SW+1)'(MAX_KERNEL);
         end
         new_col[i] = rd_data[SW'(slot_sum[i])];
      end
      new_col[MAX_KERNEL-1] = px_ff;
   end

   // coefficient table, written after the cw1 and cw2 registers to line up with the products
   coef_type coef_ff  [MAX_KERNEL][MAX_KERNEL];
   coef_type coef_sel [MAX_KERNEL][MAX_KERNEL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_KERNEL; r++) begin
            for (int c = 0; c < MAX_KERNEL; c++) begin
               coef_ff[r][c] <= '0;
            end
         end
      end else if (cw2_v_ff) begin
         for (int r = 0; r < MAX_KERNEL; r++) begin
            for (int c = 0; c < MAX_KERNEL; c++) begin
               if (TI_W'(cw2_idx_ff) == TI_W'(r * MAX_KERNEL + c)) begin
                  coef_ff[r][c] <= cw2_val_ff;
               end
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
         for (int c = 0; c < MAX_KERNEL; c++) begin
            if ((KI'(r) >= offr) && (KI'(c) >= offc)) begin
               coef_sel[r][c] = coef_ff[KI'(r) - offr][KI'(c) - offc];
            end else begin
               coef_sel[r][c] = '0;
            end
         end
      end
   end

   // chain of cells, cell MAX_KERNEL-1 takes the new column
   pix_type                  chain  [MAX_KERNEL+1][MAX_KERNEL];
   coef_type                 tap_col [MAX_KERNEL][MAX_KERNEL];
   logic signed [CSUM_W-1:0] col_sum [MAX_KERNEL];

   assign chain[MAX_KERNEL] = new_col;

   for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
      for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_tap
         assign tap_col[j][i] = coef_sel[i][j];
      end

      cv2d_cell #(.MAX_KERNEL(MAX_KERNEL)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (px_v_ff),
         .col_in   (chain[j+1]),
         .coef_col (tap_col[j]),
         .col_out  (chain[j]),
         .col_sum  (col_sum[j])
      );
   end

   // final sum, rounding and saturation
   logic signed [TOT_W-1:0] tot_in, tot_ff;
   logic signed [TOT_W:0]   rnd_v, rnd_q;
   pix_type                 res_value;
   rsp_word_type            push_word, head_word;
   logic                    head_valid;

   always_comb begin
      tot_in = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
         tot_in = tot_in + TOT_W'(col_sum[j]);
      end
   end

   always_ff @(posedge clock) begin
      tot_ff <= tot_in;
   end

   always_comb begin
      rnd_v = (TOT_W+1)'(tot_ff) + (TOT_W+1)'(ROUND_BIAS);
      rnd_q = rnd_v >>> FRAC_SHIFT;
      if (rnd_q > (TOT_W+1)'(PIX_MAX)) res_value = pix_type'(PIX_MAX);
      else if (rnd_q < (TOT_W+1)'(PIX_MIN)) res_value = pix_type'(PIX_MIN);
      else res_value = pix_type'(rnd_q);
      push_word           = m_ff[NST];
      push_word.out_value = res_value;
   end

   cv2d_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (mv_ff[NST]),
      .push_word  (push_word),
      .pop        (rsp_pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   assign rsp_pop            = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid      = head_valid;
   assign rsp_bus.out_row    = head_word.out_row;
   assign rsp_bus.out_col    = head_word.out_col;
   assign rsp_bus.out_value  = head_word.out_value;
   assign rsp_bus.frame_last = head_word.frame_last;

   // results queued or in flight
   assign res_acc = pix_acc && pos_valid;

   always_comb begin
      occ_in = occ_ff + OCC_W'(res_acc) - OCC_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

@@ sv/cv2d_chk.sv @@
// Port-level checks on the convolution block, bound to the top level.
module cv2d_chk import cv2d_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_row,
   input logic [7:0] out_col,
   input pix_type    out_value,
   input logic       frame_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_row) && $stable(out_col)
         && $stable(out_value) && $stable(frame_last))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind conv2d_valid_window cv2d_chk u_cv2d_chk (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_row    (rsp_bus.out_row),
   .out_col    (rsp_bus.out_col),
   .out_value  (rsp_bus.out_value),
   .frame_last (rsp_bus.frame_last)
);
